>>> sv/cpu8_pkg.sv
// shared types and constants of the 8-bit cpu execute block
package cpu8_pkg;

    // instruction classes sorted out by the front end
    typedef enum logic [2:0] {
        OPC_NOP     = 3'd0,
        OPC_LD16    = 3'd1,
        OPC_ST_A    = 3'd2,
        OPC_INC16   = 3'd3,
        OPC_INCDEC8 = 3'd4,
        OPC_UNSUP   = 3'd5
    } t_op_class;

    // register pair codes (opcode bits 5:4)
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // 8-bit register codes (opcode bits 5:3)
    localparam logic [2:0] R8_B   = 3'd0;
    localparam logic [2:0] R8_C   = 3'd1;
    localparam logic [2:0] R8_D   = 3'd2;
    localparam logic [2:0] R8_E   = 3'd3;
    localparam logic [2:0] R8_H   = 3'd4;
    localparam logic [2:0] R8_L   = 3'd5;
    localparam logic [2:0] R8_MEM = 3'd6;
    localparam logic [2:0] R8_A   = 3'd7;

    // opcode field values
    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_LAST    = 8'h3F;
    localparam logic [3:0] LO_LD16    = 4'h1;
    localparam logic [3:0] LO_ST_A    = 4'h2;
    localparam logic [3:0] LO_INC16   = 4'h3;
    localparam logic [2:0] LO3_INC8   = 3'd4;
    localparam logic [2:0] LO3_DEC8   = 3'd5;

    // nibble masks for the half carry test
    localparam logic [3:0] NIB_ALL  = 4'hF;
    localparam logic [3:0] NIB_NONE = 4'h0;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // decoded instruction carried from front to back
    typedef struct packed {
        t_op_class   op_class;
        logic [1:0]  pair;
        logic [2:0]  r8;
        logic        dec;
        logic [15:0] imm;
        logic [7:0]  mem;
    } t_uop;

endpackage

>>> sv/cpu8_ifs.sv
// valid/ready channel interfaces for instruction beats and result beats
interface cpu8_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  opcode;
    logic [15:0] immediate_word;
    logic [7:0]  memory_byte;

    modport source (output valid, output opcode, output immediate_word,
                    output memory_byte, input ready);
    modport sink   (input valid, input opcode, input immediate_word,
                    input memory_byte, output ready);
endinterface

interface cpu8_out_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [3:0]  flag_bits;
    logic        unsupported;

    modport source (output valid, output write_enable, output write_address,
                    output write_data, output flag_bits, output unsupported,
                    input ready);
    modport sink   (input valid, input write_enable, input write_address,
                    input write_data, input flag_bits, input unsupported,
                    output ready);
endinterface

>>> sv/cpu8_inc_dec_load_execute.sv
// top level of the 8-bit cpu execute block: front end, micro-op queue, back end
//
// Executes one instruction of the first opcode block per input beat (NOP, LD rr,n16,
// LD [rr],A with HL+/HL-, INC rr, INC/DEC r8 and [HL]) and returns one result beat for
// each. Throughput is one instruction per clock while the result sink does not stall: the back
// end updates the register file and the result register in the same cycle. When nothing stalls,
// an input beat is written into a queue entry when it is taken, and the back end then loads
// the result register from the queue head, which makes the result beat valid. The queue holds
// QUEUE_DEPTH decoded instructions, so while a result waits for its sink up to
// QUEUE_DEPTH more input beats are taken before the input stalls.
// flag_bits carries the flags after the instruction; C is never changed.
module cpu8_inc_dec_load_execute #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpu8_in_if.sink    i_item,
    cpu8_out_if.source o_result
);
    import cpu8_pkg::*;

    logic w_push, w_full, w_pop, w_head_valid;
    t_uop w_uop, w_head;

    // decode
    cpu8_front u_front (
        .i_item (i_item),
        .i_full (w_full),
        .o_push (w_push),
        .o_uop  (w_uop)
    );

    // decoupling queue
    cpu8_uop_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_uop        (w_uop),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // execute
    cpu8_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_result     (o_result)
    );

endmodule

>>> sv/cpu8_front.sv
// front end: accepts instruction beats and decodes them into micro-ops
module cpu8_front (
    cpu8_in_if.sink         i_item,
    input  logic            i_full,
    output logic            o_push,
    output cpu8_pkg::t_uop  o_uop
);
    import cpu8_pkg::*;

    logic [7:0] w_op;

    assign w_op        = i_item.opcode;
    assign i_item.ready = !i_full;
    assign o_push      = i_item.valid && !i_full;

    // classify the opcode
    always_comb begin
        o_uop.pair = w_op[5:4];
        o_uop.r8   = w_op[5:3];
        o_uop.dec  = (w_op[2:0] == LO3_DEC8);
        o_uop.imm  = i_item.immediate_word;
        o_uop.mem  = i_item.memory_byte;
        priority if (w_op > OP_LAST) begin
            o_uop.op_class = OPC_UNSUP;
        end else if (w_op == OP_NOP) begin
            o_uop.op_class = OPC_NOP;
        end else if (w_op[3:0] == LO_LD16) begin
            o_uop.op_class = OPC_LD16;
        end else if (w_op[3:0] == LO_ST_A) begin
            o_uop.op_class = OPC_ST_A;
        end else if (w_op[3:0] == LO_INC16) begin
            o_uop.op_class = OPC_INC16;
        end else if (w_op[2:0] == LO3_INC8 || w_op[2:0] == LO3_DEC8) begin
            o_uop.op_class = OPC_INCDEC8;
        end else begin
            o_uop.op_class = OPC_UNSUP;
        end
    end

endmodule

>>> sv/cpu8_uop_fifo.sv
// short micro-op queue between the front and back ends
module cpu8_uop_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cpu8_pkg::t_uop  i_uop,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output cpu8_pkg::t_uop  o_head
);
    import cpu8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_uop          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_uop;
        end
    end

endmodule

>>> sv/cpu8_back.sv
// back end: register state, instruction execution and result register
module cpu8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  cpu8_pkg::t_uop  i_head,
    output logic            o_pop,
    cpu8_out_if.source      o_result
);
    import cpu8_pkg::*;

    // architectural state
    logic [7:0]  r_a, n_a;
    logic [3:0]  r_f, n_f;
    logic [7:0]  r_b, n_b, r_c, n_c, r_d, n_d, r_e, n_e, r_h, n_h, r_l, n_l;
    logic [15:0] r_sp, n_sp;

    // result beat register
    logic        r_valid;
    logic        r_we, n_we;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic        r_unsup, n_unsup;

    logic [15:0] w_bc, w_de, w_hl, w_pair, w_pair_inc;
    logic [7:0]  w_v8, w_r8;
    logic [3:0]  w_f8;

    assign o_pop = i_head_valid && (!r_valid || o_result.ready);

    assign w_bc = {r_b, r_c};
    assign w_de = {r_d, r_e};
    assign w_hl = {r_h, r_l};

    // 16-bit operand for increment
    always_comb begin
        unique case (i_head.pair)
            PAIR_BC: w_pair = w_bc;
            PAIR_DE: w_pair = w_de;
            PAIR_HL: w_pair = w_hl;
            default: w_pair = r_sp;
        endcase
        w_pair_inc = w_pair + 16'd1;
    end

    // 8-bit operand select
    always_comb begin
        unique case (i_head.r8)
            R8_B:    w_v8 = r_b;
            R8_C:    w_v8 = r_c;
            R8_D:    w_v8 = r_d;
            R8_E:    w_v8 = r_e;
            R8_H:    w_v8 = r_h;
            R8_L:    w_v8 = r_l;
            R8_MEM:  w_v8 = i_head.mem;
            default: w_v8 = r_a;
        endcase
    end

    // 8-bit inc/dec with z, n, h and carry kept
    always_comb begin
        w_f8         = 4'b0000;
        w_f8[FLAG_C] = r_f[FLAG_C];
        if (i_head.dec) begin
            w_r8         = w_v8 - 8'd1;
            w_f8[FLAG_N] = 1'b1;
            w_f8[FLAG_H] = (w_v8[3:0] == NIB_NONE);
        end else begin
            w_r8         = w_v8 + 8'd1;
            w_f8[FLAG_H] = (w_v8[3:0] == NIB_ALL);
        end
        w_f8[FLAG_Z] = (w_r8 == 8'd0);
    end

    // next state and result
    always_comb begin
        n_a = r_a;  n_f = r_f;  n_sp = r_sp;
        n_b = r_b;  n_c = r_c;  n_d = r_d;
        n_e = r_e;  n_h = r_h;  n_l = r_l;
        n_we    = 1'b0;
        n_addr  = 16'd0;
        n_data  = 8'd0;
        n_unsup = 1'b0;
        unique case (i_head.op_class)
            OPC_NOP: begin
            end
            OPC_LD16: begin
                unique case (i_head.pair)
                    PAIR_BC: {n_b, n_c} = i_head.imm;
                    PAIR_DE: {n_d, n_e} = i_head.imm;
                    PAIR_HL: {n_h, n_l} = i_head.imm;
                    default: n_sp = i_head.imm;
                endcase
            end
            OPC_ST_A: begin
                n_we   = 1'b1;
                n_data = r_a;
                unique case (i_head.pair)
                    PAIR_BC: n_addr = w_bc;
                    PAIR_DE: n_addr = w_de;
                    PAIR_HL: begin
                        n_addr     = w_hl;
                        {n_h, n_l} = w_hl + 16'd1;
                    end
                    default: begin
                        n_addr     = w_hl;
                        {n_h, n_l} = w_hl - 16'd1;
                    end
                endcase
            end
            OPC_INC16: begin
                unique case (i_head.pair)
                    PAIR_BC: {n_b, n_c} = w_pair_inc;
                    PAIR_DE: {n_d, n_e} = w_pair_inc;
                    PAIR_HL: {n_h, n_l} = w_pair_inc;
                    default: n_sp = w_pair_inc;
                endcase
            end
            OPC_INCDEC8: begin
                n_f = w_f8;
                unique case (i_head.r8)
                    R8_B: n_b = w_r8;
                    R8_C: n_c = w_r8;
                    R8_D: n_d = w_r8;
                    R8_E: n_e = w_r8;
                    R8_H: n_h = w_r8;
                    R8_L: n_l = w_r8;
                    R8_MEM: begin
                        n_we   = 1'b1;
                        n_addr = w_hl;
                        n_data = w_r8;
                    end
                    default: n_a = w_r8;
                endcase
            end
            default: begin
                n_unsup = 1'b1;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= '0;
            r_f     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
            r_e     <= '0;
            r_h     <= '0;
            r_l     <= '0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_a  <= n_a;
                r_f  <= n_f;
                r_b  <= n_b;
                r_c  <= n_c;
                r_d  <= n_d;
                r_e  <= n_e;
                r_h  <= n_h;
                r_l  <= n_l;
                r_sp <= n_sp;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_we    <= n_we;
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_unsup <= n_unsup;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.write_enable  = r_we;
    assign o_result.write_address = r_addr;
    assign o_result.write_data    = r_data;
    assign o_result.flag_bits     = r_f;
    assign o_result.unsupported   = r_unsup;

endmodule

>>> dv/cpu8_exec_checker.sv
// checker for the cpu8 execute block: tracks register state, predicts each result beat and compares
`timescale 1ns / 1ps

module cpu8_exec_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpu8_in_if    i_item,
    cpu8_out_if   i_result,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);
    import cpu8_pkg::*;

    // one predicted result beat
    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [3:0]  flag_bits;
        logic        unsupported;
    } t_exec_result;

    // architectural state as the checker sees it
    logic [7:0]  model_a;
    logic [3:0]  model_flags;
    logic [7:0]  model_regs [6];
    logic [15:0] model_sp;

    t_exec_result expected_results [$];
    int           fail_count;
    int           checked_count;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_count;

    // register pairs live as high/low bytes in the general register file
    function automatic logic [15:0] pair_value(input logic [1:0] pair);
        return {model_regs[2 * pair], model_regs[2 * pair + 1]};
    endfunction

    task automatic load_pair(input logic [1:0] pair, input logic [15:0] value);
        model_regs[2 * pair]     = value[15:8];
        model_regs[2 * pair + 1] = value[7:0];
    endtask

    // 8-bit inc/dec with z, n, h update; carry is kept as is
    task automatic step_byte(input logic [7:0] value, input logic dec, output logic [7:0] res);
        logic [3:0] f;
        f = '0;
        f[FLAG_C] = model_flags[FLAG_C];
        if (dec) begin
            res = value - 8'd1;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = (value[3:0] == NIB_NONE);
        end else begin
            res = value + 8'd1;
            f[FLAG_H] = (value[3:0] == NIB_ALL);
        end
        f[FLAG_Z] = (res == 8'd0);
        model_flags = f;
    endtask

    // execute one instruction on the tracked state and build its result beat
    task automatic execute_instruction(input logic [7:0] op, input logic [15:0] imm,
                                       input logic [7:0] mem, output t_exec_result res);
        logic [1:0]  pair;
        logic [2:0]  r8;
        logic [15:0] hl;
        logic [7:0]  byte_out;
        pair = op[5:4];
        r8   = op[5:3];
        hl   = pair_value(PAIR_HL);
        res  = '0;
        if (op > OP_LAST) begin
            res.unsupported = 1'b1;
        end else if (op == OP_NOP) begin
            res.unsupported = 1'b0;
        end else if (op[3:0] == LO_LD16) begin
            if (pair == PAIR_SP) model_sp = imm;
            else load_pair(pair, imm);
        end else if (op[3:0] == LO_ST_A) begin
            res.write_enable = 1'b1;
            res.write_data   = model_a;
            case (pair)
                PAIR_BC, PAIR_DE: res.write_address = pair_value(pair);
                PAIR_HL: begin
                    res.write_address = hl;
                    load_pair(PAIR_HL, hl + 16'd1);
                end
                default: begin
                    res.write_address = hl;
                    load_pair(PAIR_HL, hl - 16'd1);
                end
            endcase
        end else if (op[3:0] == LO_INC16) begin
            if (pair == PAIR_SP) model_sp = model_sp + 16'd1;
            else load_pair(pair, pair_value(pair) + 16'd1);
        end else if (op[2:0] == LO3_INC8 || op[2:0] == LO3_DEC8) begin
            if (r8 == R8_MEM) begin
                step_byte(mem, op[2:0] == LO3_DEC8, byte_out);
                res.write_enable  = 1'b1;
                res.write_address = hl;
                res.write_data    = byte_out;
            end else if (r8 == R8_A) begin
                step_byte(model_a, op[2:0] == LO3_DEC8, byte_out);
                model_a = byte_out;
            end else begin
                step_byte(model_regs[r8], op[2:0] == LO3_DEC8, byte_out);
                model_regs[r8] = byte_out;
            end
        end else begin
            res.unsupported = 1'b1;
        end
        res.flag_bits = model_flags;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_exec_result want;
        if (!i_rst_n) begin
            model_a     = '0;
            model_flags = '0;
            model_sp    = '0;
            for (int i = 0; i < 6; i++) model_regs[i] = '0;
            expected_results.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no instruction outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("write_enable", want.write_enable, i_result.write_enable);
                    compare_field("write_address", want.write_address, i_result.write_address);
                    compare_field("write_data", want.write_data, i_result.write_data);
                    compare_field("flag_bits", want.flag_bits, i_result.flag_bits);
                    compare_field("unsupported", want.unsupported, i_result.unsupported);
                    checked_count++;
                end
            end
            // instruction beat updates the tracked state
            if (i_item.valid === 1'b1 && i_item.ready === 1'b1) begin
                execute_instruction(i_item.opcode, i_item.immediate_word, i_item.memory_byte,
                                    want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> dv/tb_cpu8_inc_dec_load_execute.sv
// testbench top for the cpu8 execute block: clock, reset, instruction stimulus and verdict
`timescale 1ns / 1ps

module tb_cpu8_inc_dec_load_execute;
    import cpu8_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 370;

    // opcodes outside the implemented set
    localparam logic [7:0] OP_RLCA        = 8'h07;
    localparam logic [7:0] OP_BYTE_TO_A   = 8'h3E;
    localparam logic [7:0] OP_ABOVE_BLOCK = 8'h40;
    localparam logic [7:0] OP_TOP         = 8'hFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpu8_in_if  in_ch ();
    cpu8_out_if out_ch ();

    int fail_total;
    int pending_results;
    int results_checked;

    int idle_pct;
    int stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int quiet_cycles;
    int sent_count;
    int directed_count;
    int outside_count;

    cpu8_inc_dec_load_execute u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    cpu8_exec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_total),
        .o_pending    (pending_results),
        .o_checked    (results_checked)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result sink: random stalls, plus a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_requests != holds_served) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_cpu8_inc_dec_load_execute failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] op_pair(input logic [1:0] pair, input logic [3:0] lo);
        return {2'b00, pair, lo};
    endfunction

    function automatic logic [7:0] op_r8(input logic [2:0] r8, input logic dec);
        return {2'b00, r8, dec ? LO3_DEC8 : LO3_INC8};
    endfunction

    // bytes near the half carry and wrap boundaries show up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'h10;
            4: return 8'h01;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {pick_byte(), pick_byte()};
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // one instruction beat, called at a falling edge, returns at a falling edge
    task automatic send_beat(input logic [7:0] op, input logic [15:0] imm,
                             input logic [7:0] mem);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= op;
        in_ch.immediate_word <= imm;
        in_ch.memory_byte    <= mem;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sent_count++;
        if (op > OP_LAST) outside_count++;
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [7:0] op;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 8)       op = 8'($urandom_range(255));
        else if (pick < 20) op = 8'($urandom_range(OP_LAST));
        else if (pick < 24) op = OP_NOP;
        else if (pick < 40) op = op_pair(2'($urandom_range(3)), LO_LD16);
        else if (pick < 52) op = op_pair(2'($urandom_range(3)), LO_ST_A);
        else if (pick < 62) op = op_pair(2'($urandom_range(3)), LO_INC16);
        else                op = op_r8(3'($urandom_range(7)), 1'($urandom_range(1)));
        send_beat(op, pick_word(), pick_byte());
    endtask

    // stop sending until every outstanding result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.opcode         = '0;
        in_ch.immediate_word = '0;
        in_ch.memory_byte    = '0;
        idle_pct             = 0;
        stall_pct            = 0;
        i_rst_n              = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: pair loads and wraps, flag edges, stores with hl+/hl-, memory inc/dec
        send_beat(OP_NOP, 16'hFFFF, 8'hFF);
        send_beat(op_pair(PAIR_BC, LO_LD16), 16'hFFFF, 8'h00);
        send_beat(op_pair(PAIR_BC, LO_INC16), 16'h0000, 8'h00);
        send_beat(op_pair(PAIR_DE, LO_LD16), 16'h1234, 8'h00);
        send_beat(op_pair(PAIR_HL, LO_LD16), 16'hFFFF, 8'h00);
        send_beat(op_pair(PAIR_SP, LO_LD16), 16'hFFFF, 8'h00);
        send_beat(op_pair(PAIR_SP, LO_INC16), 16'h0000, 8'h00);
        send_beat(op_r8(R8_A, 1'b0), 16'h0000, 8'h00);
        send_beat(op_r8(R8_A, 1'b1), 16'h0000, 8'h00);
        send_beat(op_r8(R8_A, 1'b1), 16'h0000, 8'h00);
        send_beat(op_r8(R8_A, 1'b0), 16'h0000, 8'h00);
        send_beat(op_pair(PAIR_HL, LO_ST_A), 16'h0000, 8'h00);
        send_beat(op_pair(PAIR_SP, LO_ST_A), 16'h0000, 8'h00);
        send_beat(op_pair(PAIR_BC, LO_ST_A), 16'h0000, 8'h00);
        send_beat(op_pair(PAIR_DE, LO_ST_A), 16'h0000, 8'h00);
        send_beat(op_r8(R8_MEM, 1'b0), 16'h0000, 8'hFF);
        send_beat(op_r8(R8_MEM, 1'b1), 16'h0000, 8'h00);
        send_beat(op_r8(R8_MEM, 1'b0), 16'h0000, 8'h0F);
        send_beat(op_r8(R8_MEM, 1'b1), 16'h0000, 8'h10);
        send_beat(op_r8(R8_B, 1'b0), 16'h0000, 8'h00);
        send_beat(op_r8(R8_L, 1'b1), 16'h0000, 8'h00);
        send_beat(op_pair(PAIR_DE, LO_INC16), 16'h0000, 8'h00);
        send_beat(OP_RLCA, 16'hFFFF, 8'hFF);
        send_beat(OP_BYTE_TO_A, 16'h0000, 8'h00);
        send_beat(OP_ABOVE_BLOCK, 16'h0000, 8'h00);
        send_beat(OP_TOP, 16'h0000, 8'h00);
        directed_count = sent_count;
        drain_results();

        // random: no idling, sender idle, sink stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 55 : (phase == 3) ? 9 : 0;
            stall_pct <= (phase == 2) ? 55 : (phase == 3) ? 9 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long sink hold while the sender keeps offering beats
                if (phase == 0 && n == 100) hold_requests <= hold_requests + 1;
                send_random();
            end
            drain_results();
        end

        repeat (8) @(negedge i_clk);
        $display("sent %0d instructions: %0d directed, %0d random, %0d above the first block",
                 sent_count, directed_count, sent_count - directed_count, outside_count);
        $display("checked %0d result beats over four idle/stall mixes and one long sink hold",
                 results_checked);
        if (fail_total == 0) begin
            $display("tb_cpu8_inc_dec_load_execute passed");
        end else begin
            $display("tb_cpu8_inc_dec_load_execute failed");
        end
        $finish;
    end

endmodule
